FILE: design/hcsv_pkg.sv
// Package for the header-tagged CSV integer parser.
// Holds shared types, character codes and configuration register indexes.
// No dependencies.
package hcsv_pkg;

  localparam int MAX_FIELDS_DEF = 8;
  localparam int HEADER_MAX     = 8;
  localparam int RESULT_CAP     = 8;
  localparam int CNT_W          = 4;
  localparam int VALUE_W        = 32;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VTAB    = 8'h0B;
  localparam logic [7:0] CH_FFEED   = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    CFG_HEADER_LENGTH = 2'd0,
    CFG_HEADER_TEXT   = 2'd1,
    CFG_FIELD_COUNT   = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    LP_HEADER = 4'b0001,
    LP_FIELDS = 4'b0010,
    LP_DONE   = 4'b0100,
    LP_REJECT = 4'b1000
  } line_phase_t;

  typedef enum logic [3:0] {
    NP_BLANKS  = 4'b0001,
    NP_SIGNED  = 4'b0010,
    NP_DIGITS  = 4'b0100,
    NP_STOPPED = 4'b1000
  } number_phase_t;

  typedef struct packed {
    logic [3:0]  header_length;
    logic [63:0] header_text;
    logic [3:0]  field_count;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } emit_t;

  function automatic int field_cap(input int max_fields);
    return (max_fields < RESULT_CAP) ? max_fields : RESULT_CAP;
  endfunction

endpackage

FILE: design/header_csv_integer_parser.sv
// Top level of the header-tagged CSV integer parser.
// Depends on hcsv_pkg, hcsv_cfg_regs, hcsv_parser and hcsv_result_buf.
//
// Text comes in one character per item on in_valid/in_stall/line_byte. Each
// character is registered and then parsed; a new item is taken every cycle
// while in_stall is low. A line whose first field matches the header has its
// next field_count fields parsed as signed decimals; the newline copies them
// into the result buffer and they leave on out_valid/out_stall as
// field_index, field_value and last_field, one per cycle while out_stall is
// low, the first in the cycle after the newline is parsed. Input keeps flowing
// while results drain; only a newline that would emit while the buffer still
// holds the previous line is held, stalling the input until the last result
// is taken. A stalled result holds its value.
// The config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// Reset clears the parse state to the start of a line and sets the
// registers to header length 2, header text 0 and field count 3.
module header_csv_integer_parser #(
  parameter int MAX_FIELDS = hcsv_pkg::MAX_FIELDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         line_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         field_index,
  output logic signed [31:0] field_value,
  output logic               last_field,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import hcsv_pkg::*;

  localparam int FieldCap = field_cap(MAX_FIELDS);

  cfg_t  cfg;
  emit_t emit;
  logic  can_load;
  logic [FieldCap-1:0][VALUE_W-1:0] snap_data;

  hcsv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hcsv_parser #(.MAX_FIELDS(MAX_FIELDS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .line_byte (line_byte),
    .cfg       (cfg),
    .can_load  (can_load),
    .emit      (emit),
    .snap_data (snap_data)
  );

  hcsv_result_buf #(.MAX_FIELDS(MAX_FIELDS)) u_result (
    .clk         (clk),
    .rst         (rst),
    .emit        (emit),
    .snap_data   (snap_data),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_index (field_index),
    .field_value (field_value),
    .last_field  (last_field)
  );

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result buffer");

  a_line_restarts_at_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_field |=> !out_valid || field_index == 3'd0)
    else $error("new line does not start at index zero");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_field |=>
      out_valid && field_index == 3'($past(field_index) + 3'd1))
    else $error("result index did not step by one");

endmodule

FILE: design/hcsv_cfg_regs.sv
// Configuration registers of the CSV integer parser.
// Depends on hcsv_pkg.
module hcsv_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output hcsv_pkg::cfg_t    cfg
);
  import hcsv_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_length <= 4'd2;
      cfg.header_text   <= 64'd0;
      cfg.field_count   <= 4'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HEADER_LENGTH: cfg.header_length <= cfg_data[3:0];
        CFG_HEADER_TEXT:   cfg.header_text   <= cfg_data;
        CFG_FIELD_COUNT:   cfg.field_count   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/hcsv_parser.sv
// Input register, line/number parsing state and field store.
// Depends on hcsv_pkg.
module hcsv_parser #(
  parameter int MAX_FIELDS = hcsv_pkg::MAX_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           line_byte,
  input  hcsv_pkg::cfg_t       cfg,
  input  logic                 can_load,
  output hcsv_pkg::emit_t      emit,
  output logic [hcsv_pkg::field_cap(MAX_FIELDS)-1:0][hcsv_pkg::VALUE_W-1:0] snap_data
);
  import hcsv_pkg::*;

  localparam int FieldCap = field_cap(MAX_FIELDS);

  logic [7:0] byte_q;
  logic       full;

  line_phase_t   lp, lp_next;
  number_phase_t np, np_next;
  logic [3:0]    hp, hp_next;
  logic          hm, hm_next;
  logic [3:0]    cf, cf_next;
  logic          neg, neg_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [VALUE_W-1:0] store [FieldCap];

  logic [3:0] hl, cnt;
  logic is_nl, is_comma, blank, digit, sign;
  logic needs_emit, advance, comma_wr;
  logic [VALUE_W-1:0] value, acc_step;

  assign hl  = (cfg.header_length > 4'(HEADER_MAX)) ? 4'(HEADER_MAX) : cfg.header_length;
  assign cnt = (cfg.field_count > 4'(FieldCap)) ? 4'(FieldCap) : cfg.field_count;

  assign is_nl    = (byte_q == CH_NEWLINE);
  assign is_comma = (byte_q == CH_COMMA);
  assign blank    = (byte_q == CH_SPACE) || (byte_q == CH_TAB) || (byte_q == CH_VTAB) ||
                    (byte_q == CH_FFEED) || (byte_q == CH_CR);
  assign digit    = (byte_q >= CH_ZERO) && (byte_q <= CH_NINE);
  assign sign     = (byte_q == CH_PLUS) || (byte_q == CH_MINUS);

  assign value    = neg ? (VALUE_W'(0) - acc) : acc;
  assign acc_step = (acc << 3) + (acc << 1) + {{(VALUE_W-4){1'b0}}, byte_q[3:0]};

  assign needs_emit = is_nl && ((lp == LP_FIELDS) || (lp == LP_DONE)) && (cnt != 4'd0);
  assign in_stall   = full && needs_emit && !can_load;
  assign advance    = full && !in_stall;

  assign emit.load  = advance && needs_emit;
  assign emit.count = cnt;

  always_comb begin
    for (int i = 0; i < FieldCap; i++) begin
      snap_data[i] = ((lp == LP_FIELDS) && (4'(i) >= cf)) ? value : store[i];
    end
  end

  always_comb begin
    lp_next  = lp;
    np_next  = np;
    hp_next  = hp;
    hm_next  = hm;
    cf_next  = cf;
    neg_next = neg;
    acc_next = acc;
    comma_wr = 1'b0;
    if (is_nl) begin
      lp_next  = LP_HEADER;
      hp_next  = 4'd0;
      hm_next  = 1'b1;
      cf_next  = 4'd0;
      np_next  = NP_BLANKS;
      neg_next = 1'b0;
      acc_next = '0;
    end else begin
      unique case (lp)
        LP_HEADER: begin
          if (is_comma) begin
            if (hm && (hp == hl)) begin
              lp_next  = (cnt == 4'd0) ? LP_DONE : LP_FIELDS;
              cf_next  = 4'd0;
              np_next  = NP_BLANKS;
              neg_next = 1'b0;
              acc_next = '0;
            end else begin
              lp_next = LP_REJECT;
            end
          end else begin
            if ((hp >= hl) || (cfg.header_text[{hp[2:0], 3'b000} +: 8] != byte_q)) begin
              hm_next = 1'b0;
            end
            if (hp != 4'd15) begin
              hp_next = hp + 4'd1;
            end
          end
        end
        LP_FIELDS: begin
          if (is_comma) begin
            comma_wr = 1'b1;
            cf_next  = cf + 4'd1;
            np_next  = NP_BLANKS;
            neg_next = 1'b0;
            acc_next = '0;
            if (cf + 4'd1 >= cnt) begin
              lp_next = LP_DONE;
            end
          end else begin
            unique case (np)
              NP_BLANKS: begin
                if (blank) begin
                  np_next = NP_BLANKS;
                end else if (sign) begin
                  neg_next = (byte_q == CH_MINUS);
                  np_next  = NP_SIGNED;
                end else if (digit) begin
                  acc_next = acc_step;
                  np_next  = NP_DIGITS;
                end else begin
                  np_next = NP_STOPPED;
                end
              end
              NP_SIGNED, NP_DIGITS: begin
                if (digit) begin
                  acc_next = acc_step;
                  np_next  = NP_DIGITS;
                end else begin
                  np_next = NP_STOPPED;
                end
              end
              NP_STOPPED: np_next = NP_STOPPED;
              default:    np_next = NP_STOPPED;
            endcase
          end
        end
        LP_DONE, LP_REJECT: lp_next = lp;
        default:            lp_next = LP_REJECT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_q <= line_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lp  <= LP_HEADER;
      np  <= NP_BLANKS;
      hp  <= 4'd0;
      hm  <= 1'b1;
      cf  <= 4'd0;
      neg <= 1'b0;
      acc <= '0;
    end else if (advance) begin
      lp  <= lp_next;
      np  <= np_next;
      hp  <= hp_next;
      hm  <= hm_next;
      cf  <= cf_next;
      neg <= neg_next;
      acc <= acc_next;
    end
  end

  // newline fills the missing tail with the open field's value
  always_ff @(posedge clk) begin
    for (int i = 0; i < FieldCap; i++) begin
      if (advance && is_nl && (lp == LP_FIELDS) && (4'(i) >= cf) && (4'(i) < cnt)) begin
        store[i] <= value;
      end else if (advance && comma_wr && (cf == 4'(i))) begin
        store[i] <= value;
      end
    end
  end

endmodule

FILE: design/hcsv_result_buf.sv
// Result buffer: holds one line's values and hands them out in index order.
// Depends on hcsv_pkg.
module hcsv_result_buf #(
  parameter int MAX_FIELDS = hcsv_pkg::MAX_FIELDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hcsv_pkg::emit_t      emit,
  input  logic [hcsv_pkg::field_cap(MAX_FIELDS)-1:0][hcsv_pkg::VALUE_W-1:0] snap_data,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           field_index,
  output logic signed [31:0]   field_value,
  output logic                 last_field
);
  import hcsv_pkg::*;

  localparam int FieldCap = field_cap(MAX_FIELDS);

  logic [VALUE_W-1:0] snap [FieldCap];
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   total;
  logic               take;

  assign take        = out_valid && !out_stall;
  assign last_field  = (idx + 4'd1 == total);
  assign can_load    = !out_valid || (take && last_field);
  assign field_index = idx[2:0];
  assign field_value = signed'(snap[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      total     <= '0;
    end else if (emit.load) begin
      out_valid <= 1'b1;
      idx       <= '0;
      total     <= emit.count;
    end else if (take) begin
      if (last_field) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      for (int i = 0; i < FieldCap; i++) begin
        snap[i] <= snap_data[i];
      end
    end else if (take) begin
      for (int i = 0; i < FieldCap - 1; i++) begin
        snap[i] <= snap[i+1];
      end
    end
  end

endmodule

FILE: test/hcsv_result_checker.sv
// Result checker for header_csv_integer_parser: tracks the register writes and
// every accepted character, predicts the emitted fields and compares them.
// Depends on hcsv_pkg.
module hcsv_result_checker #(
  parameter int MAX_FIELDS = hcsv_pkg::MAX_FIELDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         line_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         field_index,
  input  logic signed [31:0] field_value,
  input  logic               last_field,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import hcsv_pkg::*;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] value;
    logic        last;
  } field_result_t;

  field_result_t owed_q[$];
  cfg_t          regs;
  line_phase_t   line_ph;
  logic [3:0]    hdr_pos;
  logic          hdr_ok;
  logic [3:0]    cur_field;
  number_phase_t num_ph;
  logic          neg;
  logic [31:0]   acc;
  logic [31:0]   store [MAX_FIELDS];
  int            errs = 0;

  assign fail_count = errs;

  function automatic int take_count();
    int c;
    c = (regs.field_count > MAX_FIELDS) ? MAX_FIELDS : int'(regs.field_count);
    return (c > RESULT_CAP) ? RESULT_CAP : c;
  endfunction

  function automatic void restart_number();
    num_ph = NP_BLANKS;
    neg    = 1'b0;
    acc    = '0;
  endfunction

  function automatic void restart_line();
    line_ph   = LP_HEADER;
    hdr_pos   = '0;
    hdr_ok    = 1'b1;
    cur_field = '0;
    restart_number();
  endfunction

  function automatic logic [31:0] signed_total();
    return neg ? 32'd0 - acc : acc;
  endfunction

  function automatic void feed_number(logic [7:0] ch);
    logic blank;
    logic digit;
    blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VTAB) ||
            (ch == CH_FFEED) || (ch == CH_CR);
    digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (num_ph == NP_BLANKS && (ch == CH_PLUS || ch == CH_MINUS)) begin
      neg    = (ch == CH_MINUS);
      num_ph = NP_SIGNED;
    end else if (!(num_ph == NP_BLANKS && blank) && num_ph != NP_STOPPED) begin
      if (digit) begin
        acc    = acc * 32'd10 + 32'(ch - CH_ZERO);
        num_ph = NP_DIGITS;
      end else begin
        num_ph = NP_STOPPED;
      end
    end
  endfunction

  function automatic void parse_char(logic [7:0] ch);
    int            cnt;
    int            hl;
    logic [31:0]   v;
    field_result_t r;
    cnt = take_count();
    hl  = (regs.header_length > HEADER_MAX) ? HEADER_MAX : int'(regs.header_length);
    if (ch == CH_NEWLINE) begin
      if (line_ph == LP_FIELDS) begin
        v = signed_total();
        for (int i = cur_field; i < cnt; i++) store[i] = v;
        line_ph = LP_DONE;
      end
      if (line_ph == LP_DONE) begin
        for (int i = 0; i < cnt; i++) begin
          r.index = 3'(i);
          r.value = store[i];
          r.last  = (i + 1 == cnt);
          owed_q.push_back(r);
        end
      end
      restart_line();
    end else if (line_ph == LP_HEADER) begin
      if (ch == CH_COMMA) begin
        if (hdr_ok && hdr_pos == hl) begin
          line_ph   = (cnt == 0) ? LP_DONE : LP_FIELDS;
          cur_field = '0;
          restart_number();
        end else begin
          line_ph = LP_REJECT;
        end
      end else begin
        if (hdr_pos >= hl || 8'(regs.header_text >> (8 * hdr_pos)) != ch) hdr_ok = 1'b0;
        if (hdr_pos < 4'd15) hdr_pos++;
      end
    end else if (line_ph == LP_FIELDS) begin
      if (ch == CH_COMMA) begin
        if (cur_field < MAX_FIELDS) store[cur_field] = signed_total();
        cur_field++;
        restart_number();
        if (cur_field >= cnt) line_ph = LP_DONE;
      end else begin
        feed_number(ch);
      end
    end
  endfunction

  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      regs.header_length = 4'd2;
      regs.header_text   = '0;
      regs.field_count   = 4'd3;
      foreach (store[i]) store[i] = '0;
      owed_q.delete();
      restart_line();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected item: field_index %0d field_value %0d last_field %0b",
                 field_index, field_value, last_field);
          errs++;
        end else begin
          want = owed_q.pop_front();
          if (field_index !== want.index) begin
            $error("field_index: expected %0d, got %0d", want.index, field_index);
            errs++;
          end
          if (field_value !== $signed(want.value)) begin
            $error("field_value: expected %0d, got %0d", $signed(want.value), field_value);
            errs++;
          end
          if (last_field !== want.last) begin
            $error("last_field: expected %0b, got %0b", want.last, last_field);
            errs++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_HEADER_LENGTH: regs.header_length = cfg_data[3:0];
          CFG_HEADER_TEXT:   regs.header_text   = cfg_data;
          CFG_FIELD_COUNT:   regs.field_count   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_char(line_byte);
    end
    results_owed <= owed_q.size();
  end

endmodule

FILE: test/tb_header_csv_integer_parser.sv
// Testbench top for header_csv_integer_parser: directed and random CSV lines
// under several register settings, random idling on both channels.
// Depends on hcsv_pkg, the parser RTL and hcsv_result_checker.
module tb_header_csv_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import hcsv_pkg::*;

  localparam int HANG_LIMIT = 2000;
  localparam int ITEMS      = 280;
  localparam int PHASE_LEN  = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         line_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         field_index;
  logic signed [31:0] field_value;
  logic               last_field;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  int          fail_count;
  int          results_owed;
  int          quiet = 0;
  logic        gaps_on = 1'b1;
  int          chars_sent = 0;
  logic [63:0] hdr_text;
  int          hdr_len;
  int          fld_cnt;
  logic [7:0]  blanks [5] = '{CH_SPACE, CH_TAB, CH_VTAB, CH_FFEED, CH_CR};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  header_csv_integer_parser dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_byte   (line_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_index (field_index),
    .field_value (field_value),
    .last_field  (last_field),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  hcsv_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .line_byte    (line_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .field_index  (field_index),
    .field_value  (field_value),
    .last_field   (last_field),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= gaps_on && ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= HANG_LIMIT) begin
      $display("header_csv_integer_parser regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_char(input logic [7:0] ch);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    line_byte <= ch;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // registers change only with no line in flight and the result queue empty
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [3:0] hl, input logic [3:0] fc,
                            input logic [63:0] text);
    settle();
    write_reg(CFG_HEADER_LENGTH, {32'($urandom), 28'($urandom), hl});
    write_reg(CFG_HEADER_TEXT, text);
    write_reg(CFG_FIELD_COUNT, {32'($urandom), 28'($urandom), fc});
    cfg_valid <= 1'b0;
    hdr_text = text;
    hdr_len  = (hl > HEADER_MAX) ? HEADER_MAX : int'(hl);
    fld_cnt  = (fc > MAX_FIELDS_DEF) ? MAX_FIELDS_DEF : int'(fc);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    ch = 8'($urandom);
    if (ch == CH_COMMA || ch == CH_NEWLINE) ch = 8'h5A;
    return ch;
  endfunction

  function automatic logic [63:0] safe_header();
    logic [63:0] t;
    for (int i = 0; i < 8; i++) t[8*i +: 8] = text_char();
    return t;
  endfunction

  task automatic random_field();
    int sgn;
    int nd;
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
      send_char(blanks[$urandom_range(4)]);
    sgn = $urandom_range(9);
    if (sgn <= 2) send_char(CH_MINUS);
    else if (sgn <= 4) send_char(CH_PLUS);
    else if (sgn == 5) send_text("-+");
    nd = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    repeat (nd) send_char(CH_ZERO + 8'($urandom_range(9)));
    if ($urandom_range(4) == 0) send_char(text_char());
  endtask

  // mostly well-formed lines; some noise, some wrong headers, some lines with no comma
  task automatic random_line(output int counted);
    int kind;
    int start;
    int fields;
    kind   = $urandom_range(99);
    start  = chars_sent;
    counted = 0;
    if (kind < 8) begin
      repeat ($urandom_range(1, 10)) send_char(8'($urandom));
      send_char(CH_NEWLINE);
    end else begin
      for (int i = 0; i < hdr_len; i++) send_char(hdr_text[8*i +: 8]);
      if (kind < 16) send_char(text_char());
      fields = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, fld_cnt + 1);
      repeat (fields) begin
        send_char(CH_COMMA);
        random_field();
      end
      send_char(CH_NEWLINE);
    end
    counted = chars_sent - start;
  endtask

  initial begin
    logic [63:0] hdr;
    int counted;
    int spent;
    int n;
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: two NUL header characters, three fields
    send_char(8'h00);
    send_char(8'h00);
    send_text(",5\n");

    hdr = safe_header();
    hdr[7:0] = "G";
    set_config(4'd1, 4'd3, hdr);
    send_text("G,-2147483648,+4294967297\n");
    send_text("G\n");
    send_text("H,7\n");
    send_text("G, \t-0x5,");
    send_char(8'hFF);
    send_char(CH_NEWLINE);
    send_text("G,1,2,3,4\n");

    counted = chars_sent;
    phase   = 0;
    while (counted < ITEMS) begin
      case (phase)
        0:       set_config(4'd1, 4'd1, safe_header());
        1:       set_config(4'd8, 4'd8, safe_header());
        2:       set_config(4'd0, 4'd3, safe_header());
        3:       set_config(4'd15, 4'd15, safe_header());
        4:       set_config(4'd3, 4'd0, safe_header());
        default: set_config(4'($urandom), 4'($urandom), safe_header());
      endcase
      gaps_on <= (phase != 1);
      spent = 0;
      while (spent < PHASE_LEN && counted < ITEMS) begin
        random_line(n);
        spent   += n;
        counted += n;
      end
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("header_csv_integer_parser regression: pass");
    end else begin
      $display("header_csv_integer_parser regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
design/hcsv_pkg.sv
design/hcsv_cfg_regs.sv
design/hcsv_parser.sv
design/hcsv_result_buf.sv
design/header_csv_integer_parser.sv
test/hcsv_result_checker.sv
test/tb_header_csv_integer_parser.sv
